>>> design/bfa_pkg.sv
// Shared types, codes and constants of the bitmap frame allocator.
`default_nettype none

package bfa_pkg;

  // Default geometry: number of frames and bytes per frame (a power of two).
  localparam int unsigned FRAME_CAPACITY_DEF = 262144;
  localparam int unsigned FRAME_BYTES_DEF    = 4096;

  // Fixed field widths.
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned KIB_W      = 21;
  localparam int unsigned UPPER_W    = 22;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Bitmap word geometry.
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_IDX_W = 5;

  // One MiB below the upper memory, and log2 of bytes per KiB.
  localparam int unsigned LOW_MEM_KIB = 1024;
  localparam int unsigned KIB_SHIFT   = 10;

  // Stream packing widths.
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 80;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_MEM  = 2'd1,
    ST_NO_INFO = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEM_INFO_VALID    = 2'd0,
    CFG_UPPER_MEM_KIB     = 2'd1,
    CFG_RESERVED_END_ADDR = 2'd2
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic set_no_info;
    logic init_load;
    logic sweep;
    logic alloc_start;
    logic free_start;
    logic read;
    logic scan_next;
    logic alloc_take;
    logic alloc_fail;
    logic free_eval;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic info_valid;
    logic free_hit;
    logic sweep_last;
    logic word_full;
    logic alloc_fit;
    logic scan_end;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> design/bfa_ctrl.sv
// Controller state machine of the bitmap frame allocator.
`default_nettype none

module bfa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  input  wire bfa_pkg::dp_sts_t   sts_i,
  output bfa_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_SWEEP  = 7'b0001000,
    S_READ   = 7'b0010000,
    S_EVAL   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and command decode.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.cmd)
          bfa_pkg::CMD_INIT: begin
            if (sts_i.info_valid) begin
              cmd_o.init_load = 1'b1;
              state_d         = S_SWEEP;
            end else begin
              cmd_o.set_no_info = 1'b1;
              state_d           = S_RESP;
            end
          end
          bfa_pkg::CMD_ALLOC: begin
            cmd_o.alloc_start = 1'b1;
            state_d           = S_READ;
          end
          bfa_pkg::CMD_FREE: begin
            if (sts_i.free_hit) begin
              cmd_o.free_start = 1'b1;
              state_d          = S_READ;
            end else begin
              state_d = S_RESP;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_RESP;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.cmd == bfa_pkg::CMD_FREE) begin
          cmd_o.free_eval = 1'b1;
          state_d         = S_RESP;
        end else if (!sts_i.word_full) begin
          if (sts_i.alloc_fit) begin
            cmd_o.alloc_take = 1'b1;
          end else begin
            cmd_o.alloc_fail = 1'b1;
          end
          state_d = S_RESP;
        end else if (sts_i.scan_end) begin
          cmd_o.alloc_fail = 1'b1;
          state_d          = S_RESP;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_READ;
        end
      end
      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output slot: a loaded result waits here until the receiver takes it.
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  // State registers; reset starts the clearing pass over the bitmap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> design/bfa_datapath.sv
// Datapath of the bitmap frame allocator: bitmap memory, counters and result registers.
`default_nettype none

module bfa_datapath #(
  parameter int unsigned FRAME_CAPACITY = bfa_pkg::FRAME_CAPACITY_DEF,
  parameter int unsigned FRAME_BYTES    = bfa_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bfa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [bfa_pkg::CMD_W-1:0]         in_command_i,
  input  wire logic [bfa_pkg::ADDR_W-1:0]        in_release_addr_i,
  input  wire bfa_pkg::ctrl_cmd_t                cmd_i,
  output bfa_pkg::dp_sts_t                       sts_o,
  output logic [bfa_pkg::ADDR_W-1:0]             out_frame_addr_o,
  output logic [bfa_pkg::STATUS_W-1:0]           out_status_o,
  output logic [bfa_pkg::KIB_W-1:0]              out_managed_kib_o,
  output logic [bfa_pkg::KIB_W-1:0]              out_used_kib_o
);

  localparam int unsigned MAP_WORDS   = (FRAME_CAPACITY + bfa_pkg::WORD_BITS - 1)
                                        / bfa_pkg::WORD_BITS;
  localparam int unsigned WW          = $clog2(MAP_WORDS);
  localparam int unsigned FRAME_W     = WW + bfa_pkg::BIT_IDX_W;
  localparam int unsigned CNT_W       = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned SHIFT       = $clog2(FRAME_BYTES);
  localparam int unsigned KPF_SHIFT   = SHIFT - bfa_pkg::KIB_SHIFT;
  localparam int unsigned FULL_W      = FRAME_W + SHIFT;
  localparam int unsigned WIDE_W      = bfa_pkg::ADDR_W + 1;
  localparam int unsigned KIB_FULL_W  = CNT_W + KPF_SHIFT;

  // Configuration registers.
  logic                            mem_info_valid_q;
  logic [bfa_pkg::UPPER_W-1:0]     upper_mem_kib_q;
  logic [bfa_pkg::ADDR_W-1:0]      reserved_end_q;

  // Item and scan state.
  bfa_pkg::cmd_e                   cmd_q;
  logic [bfa_pkg::ADDR_W-1:0]      rel_addr_q;
  logic [WW-1:0]                   ptr_q;
  logic [bfa_pkg::BIT_IDX_W-1:0]   free_bit_q;
  logic [CNT_W-1:0]                reserve_q;
  logic [CNT_W-1:0]                managed_q;
  logic [CNT_W-1:0]                used_q;
  logic [bfa_pkg::ADDR_W-1:0]      frame_addr_q;
  bfa_pkg::status_e                status_q;
  logic [bfa_pkg::WORD_BITS-1:0]   rdata_q;

  // Result registers.
  logic [bfa_pkg::ADDR_W-1:0]      out_frame_addr_q;
  logic [bfa_pkg::STATUS_W-1:0]    out_status_q;
  logic [bfa_pkg::KIB_W-1:0]       out_managed_kib_q;
  logic [bfa_pkg::KIB_W-1:0]       out_used_kib_q;

  // Bitmap memory.
  logic [bfa_pkg::WORD_BITS-1:0]   map_mem [MAP_WORDS];
  logic                            mem_we;
  logic [bfa_pkg::WORD_BITS-1:0]   mem_wdata;

  // Init arithmetic: managed frame count and reserved frame count, both capped.
  logic [bfa_pkg::ADDR_W-1:0]      frames_raw;
  logic [CNT_W-1:0]                frames_cap;
  logic [WIDE_W-1:0]               reserve_raw;
  logic [CNT_W-1:0]                reserve_cap;

  always_comb begin
    frames_raw  = (bfa_pkg::ADDR_W'(bfa_pkg::LOW_MEM_KIB)
                   + bfa_pkg::ADDR_W'(upper_mem_kib_q)) >> KPF_SHIFT;
    frames_cap  = (frames_raw > bfa_pkg::ADDR_W'(FRAME_CAPACITY))
                  ? CNT_W'(FRAME_CAPACITY) : CNT_W'(frames_raw);
    reserve_raw = (WIDE_W'(reserved_end_q) + WIDE_W'(FRAME_BYTES - 1)) >> SHIFT;
    reserve_cap = (reserve_raw > WIDE_W'(FRAME_CAPACITY))
                  ? CNT_W'(FRAME_CAPACITY) : CNT_W'(reserve_raw);
  end

  // Sweep word: all ones below the reserved boundary, a partial mask at it.
  logic [bfa_pkg::ADDR_W-1:0]      res_word;
  logic [bfa_pkg::BIT_IDX_W-1:0]   res_rem;
  logic [bfa_pkg::WORD_BITS-1:0]   sweep_mask;

  always_comb begin
    res_word = bfa_pkg::ADDR_W'(reserve_q >> bfa_pkg::BIT_IDX_W);
    res_rem  = reserve_q[bfa_pkg::BIT_IDX_W-1:0];
    if (bfa_pkg::ADDR_W'(ptr_q) < res_word) begin
      sweep_mask = '1;
    end else if (bfa_pkg::ADDR_W'(ptr_q) == res_word) begin
      sweep_mask = (bfa_pkg::WORD_BITS'(1) << res_rem) - bfa_pkg::WORD_BITS'(1);
    end else begin
      sweep_mask = '0;
    end
  end

  // Lowest clear bit of the word read back.
  logic [bfa_pkg::WORD_BITS-1:0]   inv_word;
  logic [bfa_pkg::WORD_BITS-1:0]   low_zero;
  logic [bfa_pkg::BIT_IDX_W-1:0]   low_idx;
  logic [FRAME_W-1:0]              alloc_frame;
  logic [FULL_W-1:0]               alloc_bytes;

  always_comb begin
    inv_word = ~rdata_q;
    low_zero = inv_word & (~inv_word + bfa_pkg::WORD_BITS'(1));
    low_idx  = '0;
    for (int i = 0; i < int'(bfa_pkg::WORD_BITS); i++) begin
      if (low_zero[i]) begin
        low_idx = low_idx | bfa_pkg::BIT_IDX_W'(i);
      end
    end
    alloc_frame = {ptr_q, low_idx};
    alloc_bytes = {alloc_frame, {SHIFT{1'b0}}};
  end

  // Frame named by a free request.
  logic [bfa_pkg::ADDR_W-1:0]      free_frame_full;
  logic [FRAME_W-1:0]              free_frame;
  logic [bfa_pkg::WORD_BITS-1:0]   free_onehot;
  logic                            free_bit_set;

  always_comb begin
    free_frame_full = rel_addr_q >> SHIFT;
    free_frame      = FRAME_W'(free_frame_full);
    free_onehot     = bfa_pkg::WORD_BITS'(1) << free_bit_q;
    free_bit_set    = |(rdata_q & free_onehot);
  end

  // Status towards the controller.
  always_comb begin
    sts_o.cmd        = cmd_q;
    sts_o.info_valid = mem_info_valid_q;
    sts_o.free_hit   = free_frame_full < bfa_pkg::ADDR_W'(managed_q);
    sts_o.sweep_last = ptr_q == WW'(MAP_WORDS - 1);
    sts_o.word_full  = &rdata_q;
    sts_o.alloc_fit  = bfa_pkg::ADDR_W'(alloc_frame) < bfa_pkg::ADDR_W'(managed_q);
    sts_o.scan_end   = ((bfa_pkg::ADDR_W'(ptr_q) + bfa_pkg::ADDR_W'(1)) << bfa_pkg::BIT_IDX_W)
                       >= bfa_pkg::ADDR_W'(managed_q);
  end

  // Memory write selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = sweep_mask;
    if (cmd_i.sweep) begin
      mem_we = 1'b1;
    end else if (cmd_i.alloc_take) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_q | low_zero;
    end else if (cmd_i.free_eval && free_bit_set) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_q & ~free_onehot;
    end
  end

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[ptr_q] <= mem_wdata;
    end
    if (cmd_i.read) begin
      rdata_q <= map_mem[ptr_q];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_info_valid_q <= 1'b0;
      upper_mem_kib_q  <= '0;
      reserved_end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfa_pkg::CFG_MEM_INFO_VALID: begin
          mem_info_valid_q <= cfg_data_i[0];
        end
        bfa_pkg::CFG_UPPER_MEM_KIB: begin
          upper_mem_kib_q <= cfg_data_i[bfa_pkg::UPPER_W-1:0];
        end
        bfa_pkg::CFG_RESERVED_END_ADDR: begin
          reserved_end_q <= cfg_data_i[bfa_pkg::ADDR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Scan pointer, counters and the reserved boundary of the sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      reserve_q <= '0;
      managed_q <= '0;
      used_q    <= '0;
    end else begin
      if (cmd_i.init_load) begin
        ptr_q     <= '0;
        reserve_q <= reserve_cap;
        managed_q <= frames_cap;
        used_q    <= reserve_cap;
      end else if (cmd_i.sweep) begin
        ptr_q <= sts_o.sweep_last ? '0 : ptr_q + WW'(1);
      end else if (cmd_i.alloc_start) begin
        ptr_q <= '0;
      end else if (cmd_i.free_start) begin
        ptr_q <= free_frame[FRAME_W-1:bfa_pkg::BIT_IDX_W];
      end else if (cmd_i.scan_next) begin
        ptr_q <= ptr_q + WW'(1);
      end
      if (cmd_i.alloc_take) begin
        used_q <= used_q + CNT_W'(1);
      end else if (cmd_i.free_eval && free_bit_set) begin
        used_q <= used_q - CNT_W'(1);
      end
    end
  end

  // Item capture and per-item result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q        <= bfa_pkg::cmd_e'(in_command_i);
      rel_addr_q   <= in_release_addr_i;
      frame_addr_q <= '0;
      status_q     <= bfa_pkg::ST_OK;
    end
    if (cmd_i.free_start) begin
      free_bit_q <= free_frame[bfa_pkg::BIT_IDX_W-1:0];
    end
    if (cmd_i.set_no_info) begin
      status_q <= bfa_pkg::ST_NO_INFO;
    end
    if (cmd_i.alloc_fail) begin
      status_q <= bfa_pkg::ST_NO_MEM;
    end
    if (cmd_i.alloc_take) begin
      frame_addr_q <= bfa_pkg::ADDR_W'(alloc_bytes);
    end
  end

  // Result registers, loaded once the counters hold the item's outcome.
  logic [KIB_FULL_W-1:0] managed_kib_full;
  logic [KIB_FULL_W-1:0] used_kib_full;

  assign managed_kib_full = KIB_FULL_W'(managed_q) << KPF_SHIFT;
  assign used_kib_full    = KIB_FULL_W'(used_q) << KPF_SHIFT;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_frame_addr_q  <= frame_addr_q;
      out_status_q      <= status_q;
      out_managed_kib_q <= bfa_pkg::KIB_W'(managed_kib_full);
      out_used_kib_q    <= bfa_pkg::KIB_W'(used_kib_full);
    end
  end

  assign out_frame_addr_o  = out_frame_addr_q;
  assign out_status_o      = out_status_q;
  assign out_managed_kib_o = out_managed_kib_q;
  assign out_used_kib_o    = out_used_kib_q;

endmodule

`default_nettype wire

>>> design/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: controller and datapath.
//
// Usage: a command transaction on the slave stream carries the command in
// tuser (init, allocate, free, no operation) and the byte address to free in
// tdata. Every command gives exactly one result transaction on the master
// stream: frame address, managed and used KiB in tdata, status in tuser.
// Configuration registers (memory info flag, upper memory size, reserved
// end address) are written through cfg_we_i / cfg_idx_i / cfg_data_i while
// no command is in flight; writes to index three are ignored.
// Steps: a no-operation, a free outside the managed range or an init
// without memory info goes straight to the response; a free reads the
// bitmap word of its frame and clears the frame's bit. Allocate reads
// bitmap words one at a time from word zero until a word is not full or
// the managed range ends; each word passes the registered bitmap read and
// then the state that examines it. Init rewrites the whole bitmap, one word a cycle.
// Reset: the same sweep clears the bitmap after reset; tready stays low
// while it runs. When the receiver stalls, the result waits in the output
// register, the next command is still accepted and processed, and its
// result is held back until the output register is free.
// FRAME_BYTES must be a power of two.
`default_nettype none

module bitmap_frame_allocator #(
  parameter int unsigned FRAME_CAPACITY = bfa_pkg::FRAME_CAPACITY_DEF,
  parameter int unsigned FRAME_BYTES    = bfa_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [bfa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bfa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Command stream.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [bfa_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [31:0] release_addr
  input  wire logic [bfa_pkg::CMD_W-1:0]       s_axis_tuser,  // [1:0] command
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] frame_addr, [52:32] managed_kib, [73:53] used_kib, [79:74] zero
  output logic [bfa_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  output logic [bfa_pkg::STATUS_W-1:0]         m_axis_tuser   // [1:0] status
);

  bfa_pkg::ctrl_cmd_t             ctrl_cmd;
  bfa_pkg::dp_sts_t               dp_sts;
  logic [bfa_pkg::ADDR_W-1:0]     frame_addr;
  logic [bfa_pkg::KIB_W-1:0]      managed_kib;
  logic [bfa_pkg::KIB_W-1:0]      used_kib;

  bfa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (dp_sts),
    .cmd_o         (ctrl_cmd)
  );

  bfa_datapath #(
    .FRAME_CAPACITY (FRAME_CAPACITY),
    .FRAME_BYTES    (FRAME_BYTES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_command_i      (s_axis_tuser),
    .in_release_addr_i (s_axis_tdata),
    .cmd_i             (ctrl_cmd),
    .sts_o             (dp_sts),
    .out_frame_addr_o  (frame_addr),
    .out_status_o      (m_axis_tuser),
    .out_managed_kib_o (managed_kib),
    .out_used_kib_o    (used_kib)
  );

  // Pack the result fields, lowest field first, padded to whole bytes.
  assign m_axis_tdata = bfa_pkg::M_TDATA_W'({used_kib, managed_kib, frame_addr});

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench of the bitmap frame allocator with directed and random command traffic.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FRAMES       = bfa_pkg::FRAME_CAPACITY_DEF;
  localparam int unsigned PAGE_BYTES   = bfa_pkg::FRAME_BYTES_DEF;
  localparam int unsigned PAGE_SHIFT   = $clog2(bfa_pkg::FRAME_BYTES_DEF);
  localparam int unsigned KIB_PER_PAGE = bfa_pkg::FRAME_BYTES_DEF >> bfa_pkg::KIB_SHIFT;
  localparam int unsigned MAP_WORDS    = bfa_pkg::FRAME_CAPACITY_DEF / bfa_pkg::WORD_BITS;
  localparam int unsigned RANDOM_ITEMS = 520;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned IDLE_LIMIT   = 100000;
  localparam int unsigned REPORT_LIMIT = 40;

  // One expected result transaction.
  typedef struct packed {
    logic [bfa_pkg::ADDR_W-1:0] frame_addr;
    bfa_pkg::status_e           status;
    logic [bfa_pkg::KIB_W-1:0]  managed_kib;
    logic [bfa_pkg::KIB_W-1:0]  used_kib;
  } alloc_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [bfa_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [bfa_pkg::S_TDATA_W-1:0]  s_axis_tdata;  // [31:0] release_addr
  logic [bfa_pkg::CMD_W-1:0]      s_axis_tuser;  // [1:0] command
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  // [31:0] frame_addr, [52:32] managed_kib, [73:53] used_kib, [79:74] zero
  logic [bfa_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic [bfa_pkg::STATUS_W-1:0]   m_axis_tuser;  // [1:0] status

  // Shadow copy of the allocator state and its registers.
  logic [bfa_pkg::WORD_BITS-1:0]  usage_words [MAP_WORDS];
  int unsigned                    busy_frames;
  int unsigned                    managed_count;
  logic                           info_valid_reg;
  logic [bfa_pkg::UPPER_W-1:0]    upper_kib_reg;
  logic [bfa_pkg::ADDR_W-1:0]     reserve_end_reg;
  int unsigned                    granted_frames [$];
  alloc_result_t                  pending_results [$];

  int unsigned mismatch_count   = 0;
  int unsigned command_count    = 0;
  int unsigned result_count     = 0;
  int unsigned out_of_mem_count = 0;
  int unsigned no_info_count    = 0;
  int unsigned send_calm        = 0;
  int unsigned recv_calm        = 0;
  int unsigned idle_cycles      = 0;

  bitmap_frame_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Init: clear the map, size the managed range and mark the reserved frames as used.
  function automatic void rebuild_map();
    longint unsigned frames;
    longint unsigned reserve;
    int unsigned     w;
    frames  = (longint'(bfa_pkg::LOW_MEM_KIB) + longint'(upper_kib_reg))
              / longint'(KIB_PER_PAGE);
    if (frames > longint'(FRAMES)) frames = longint'(FRAMES);
    reserve = (longint'(reserve_end_reg) + longint'(PAGE_BYTES) - 1) / longint'(PAGE_BYTES);
    if (reserve > longint'(FRAMES)) reserve = longint'(FRAMES);
    managed_count = 32'(frames);
    busy_frames   = 32'(reserve);
    for (w = 0; w < MAP_WORDS; w++) begin
      if (longint'((w + 1) * bfa_pkg::WORD_BITS) <= reserve) begin
        usage_words[w] = '1;
      end else if (longint'(w * bfa_pkg::WORD_BITS) < reserve) begin
        usage_words[w] = bfa_pkg::WORD_BITS'(
            (64'd1 << (reserve - longint'(w * bfa_pkg::WORD_BITS))) - 64'd1);
      end else begin
        usage_words[w] = '0;
      end
    end
    granted_frames.delete();
  endfunction

  // First fit: skip full words, give up at the first frame beyond the managed range.
  function automatic logic grab_frame(output logic [bfa_pkg::ADDR_W-1:0] addr);
    int unsigned w;
    int unsigned b;
    int unsigned f;
    addr = '0;
    for (w = 0; w < MAP_WORDS; w++) begin
      if (usage_words[w] != '1) begin
        for (b = 0; b < bfa_pkg::WORD_BITS; b++) begin
          f = w * bfa_pkg::WORD_BITS + b;
          if (f >= managed_count) return 1'b0;
          if (!usage_words[w][b]) begin
            usage_words[w][b] = 1'b1;
            busy_frames++;
            granted_frames.push_back(f);
            addr = bfa_pkg::ADDR_W'(f << PAGE_SHIFT);
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // A frame is released only when it is managed and currently in use.
  function automatic void drop_frame(input logic [bfa_pkg::ADDR_W-1:0] addr);
    int unsigned f;
    f = 32'(addr >> PAGE_SHIFT);
    if (f < managed_count) begin
      if (usage_words[f / bfa_pkg::WORD_BITS][f % bfa_pkg::WORD_BITS]) begin
        usage_words[f / bfa_pkg::WORD_BITS][f % bfa_pkg::WORD_BITS] = 1'b0;
        busy_frames--;
      end
    end
  endfunction

  // Works out the result of one command and advances the shadow state.
  function automatic alloc_result_t predict_allocator(input bfa_pkg::cmd_e op,
                                                      input logic [bfa_pkg::ADDR_W-1:0] addr);
    alloc_result_t              r;
    logic [bfa_pkg::ADDR_W-1:0] taken;
    r.frame_addr = '0;
    r.status     = bfa_pkg::ST_OK;
    case (op)
      bfa_pkg::CMD_INIT: begin
        if (info_valid_reg) rebuild_map();
        else r.status = bfa_pkg::ST_NO_INFO;
      end
      bfa_pkg::CMD_ALLOC: begin
        if (grab_frame(taken)) r.frame_addr = taken;
        else r.status = bfa_pkg::ST_NO_MEM;
      end
      bfa_pkg::CMD_FREE: begin
        drop_frame(addr);
      end
      default: begin
      end
    endcase
    r.managed_kib = bfa_pkg::KIB_W'(managed_count * KIB_PER_PAGE);
    r.used_kib    = bfa_pkg::KIB_W'(busy_frames * KIB_PER_PAGE);
    return r;
  endfunction

  // Wait length before the next transaction, with occasional stretches without any gap.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic void check_field(input string field,
                                      input logic [bfa_pkg::ADDR_W-1:0] want,
                                      input logic [bfa_pkg::ADDR_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  // Register write; the shadow copy follows once the write edge has passed.
  task automatic write_reg(input bfa_pkg::cfg_idx_e idx,
                           input logic [bfa_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      bfa_pkg::CFG_MEM_INFO_VALID:    info_valid_reg  = value[0];
      bfa_pkg::CFG_UPPER_MEM_KIB:     upper_kib_reg   = value[bfa_pkg::UPPER_W-1:0];
      bfa_pkg::CFG_RESERVED_END_ADDR: reserve_end_reg = value;
      default: begin
      end
    endcase
  endtask

  task automatic configure(input logic info, input logic [bfa_pkg::UPPER_W-1:0] upper,
                           input logic [bfa_pkg::ADDR_W-1:0] res_end);
    write_reg(bfa_pkg::CFG_MEM_INFO_VALID, bfa_pkg::CFG_DATA_W'(info));
    write_reg(bfa_pkg::CFG_UPPER_MEM_KIB, bfa_pkg::CFG_DATA_W'(upper));
    write_reg(bfa_pkg::CFG_RESERVED_END_ADDR, res_end);
  endtask

  // Sends one command transaction; tvalid stays high when the next one follows at once.
  task automatic send_cmd(input bfa_pkg::cmd_e op, input logic [bfa_pkg::ADDR_W-1:0] addr);
    int unsigned gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_allocator(op, addr));
    command_count++;
  endtask

  // Drops tvalid and waits until every result has come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Every command before any configuration: init must report missing memory information.
  task automatic test_no_mem_info();
    send_cmd(bfa_pkg::CMD_INIT, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_FREE, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_NOP, 32'hFFFF_FFFF);
  endtask

  // Smallest memory, nothing reserved: frame zero, reuse after free, ignored frees.
  task automatic test_first_fit_basic();
    wait_idle();
    configure(1'b1, '0, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_INIT, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_FREE, 32'h0000_0FFF);
    send_cmd(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_FREE, 32'hFFFF_FFFF);
    send_cmd(bfa_pkg::CMD_FREE, 32'h0000_5000);
    send_cmd(bfa_pkg::CMD_NOP, 32'h0000_0000);
  endtask

  // A reserved end of one byte reserves the whole first frame, which free may release.
  task automatic test_reserved_range();
    wait_idle();
    write_reg(bfa_pkg::CFG_RESERVED_END_ADDR, 32'h0000_0001);
    send_cmd(bfa_pkg::CMD_INIT, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_FREE, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
  endtask

  // Largest memory with every frame reserved: full scans, and the topmost frame.
  task automatic test_full_capacity();
    wait_idle();
    configure(1'b1, '1, 32'hFFFF_FFFF);
    send_cmd(bfa_pkg::CMD_INIT, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_FREE, bfa_pkg::ADDR_W'((FRAMES - 1) << PAGE_SHIFT));
    send_cmd(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_FREE, 32'hFFFF_FFFF);
  endtask

  // Reserved range beyond the managed range: used size exceeds the managed size.
  task automatic test_reserve_beyond_managed();
    wait_idle();
    configure(1'b1, '0, 32'h0020_0000);
    send_cmd(bfa_pkg::CMD_INIT, 32'h0000_0000);
    send_cmd(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
  endtask

  // Random commands; frees mostly hit granted frames so that the map churns.
  task automatic run_random_phase(input int unsigned quota);
    int unsigned                counted;
    int unsigned                pick;
    int unsigned                slot;
    int unsigned                frame;
    bfa_pkg::cmd_e              op;
    logic [bfa_pkg::ADDR_W-1:0] addr;
    counted = 0;
    while (counted < quota) begin
      pick = $urandom_range(0, 99);
      addr = $urandom;
      if (pick < 3) op = bfa_pkg::CMD_INIT;
      else if (pick < 50) op = bfa_pkg::CMD_ALLOC;
      else if (pick < 92) op = bfa_pkg::CMD_FREE;
      else op = bfa_pkg::CMD_NOP;
      if (op == bfa_pkg::CMD_FREE) begin
        pick = $urandom_range(0, 9);
        if (pick < 6 && granted_frames.size() > 0) begin
          slot  = $urandom_range(0, granted_frames.size() - 1);
          frame = granted_frames[slot];
          granted_frames.delete(slot);
          addr  = bfa_pkg::ADDR_W'(frame << PAGE_SHIFT)
                  | (addr & bfa_pkg::ADDR_W'(PAGE_BYTES - 1));
        end else if (pick < 8) begin
          frame = $urandom_range(0, managed_count + 32);
          addr  = bfa_pkg::ADDR_W'(frame << PAGE_SHIFT)
                  | (addr & bfa_pkg::ADDR_W'(PAGE_BYTES - 1));
        end
      end
      send_cmd(op, addr);
      counted++;
    end
  endtask

  // Several settings, each followed by an init and a burst of random traffic.
  task automatic test_random_traffic();
    int unsigned                 phase;
    int unsigned                 frames;
    int unsigned                 spare;
    logic                        info;
    logic [bfa_pkg::UPPER_W-1:0] upper;
    logic [bfa_pkg::ADDR_W-1:0]  res_end;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      info    = 1'b1;
      upper   = bfa_pkg::UPPER_W'($urandom_range(0, 4194303));
      res_end = $urandom_range(0, 32'h0010_0000);
      case (phase)
        0: begin
          // Sixteen free frames at the top of the smallest memory.
          upper   = '0;
          res_end = 32'h000F_0000;
        end
        2: begin
          upper   = '1;
          res_end = $urandom_range(0, 32'h0000_4000);
        end
        3: begin
          // Init fails here, so the previous map carries on.
          info    = 1'b0;
          res_end = $urandom;
        end
        4: begin
          // Only a handful of managed frames left free.
          upper   = bfa_pkg::UPPER_W'($urandom_range(0, 4096));
          frames  = (bfa_pkg::LOW_MEM_KIB + 32'(upper)) / KIB_PER_PAGE;
          spare   = $urandom_range(1, 24);
          res_end = bfa_pkg::ADDR_W'((frames - spare - 1) * PAGE_BYTES
                                     + $urandom_range(1, PAGE_BYTES));
        end
        default: begin
        end
      endcase
      configure(info, upper, res_end);
      send_cmd(bfa_pkg::CMD_INIT, $urandom);
      run_random_phase(RANDOM_ITEMS / PHASES);
    end
  endtask

  // Result side: random stalls, then each transaction is checked against the oldest expectation.
  initial begin : result_monitor
    alloc_result_t want;
    int unsigned   stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, expected nothing, actual 0x%0h / %0d",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        if (want.status == bfa_pkg::ST_NO_MEM) out_of_mem_count++;
        if (want.status == bfa_pkg::ST_NO_INFO) no_info_count++;
        check_field("frame_addr", want.frame_addr, m_axis_tdata[31:0]);
        check_field("status", bfa_pkg::ADDR_W'(want.status), bfa_pkg::ADDR_W'(m_axis_tuser));
        check_field("managed_kib", bfa_pkg::ADDR_W'(want.managed_kib),
                    bfa_pkg::ADDR_W'(m_axis_tdata[52:32]));
        check_field("used_kib", bfa_pkg::ADDR_W'(want.used_kib),
                    bfa_pkg::ADDR_W'(m_axis_tdata[73:53]));
      end
    end
  end

  // Watchdog: too long without any transaction on either stream ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned w;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = bfa_pkg::CFG_MEM_INFO_VALID;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = bfa_pkg::CMD_NOP;
    busy_frames     = 0;
    managed_count   = 0;
    info_valid_reg  = 1'b0;
    upper_kib_reg   = '0;
    reserve_end_reg = '0;
    for (w = 0; w < MAP_WORDS; w++) usage_words[w] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_no_mem_info();
    test_first_fit_basic();
    test_reserved_range();
    test_full_capacity();
    test_reserve_beyond_managed();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d commands and checked %0d results, %0d mismatching fields.",
             command_count, result_count, mismatch_count);
    $display("Seen %0d out-of-memory allocations and %0d inits without memory information.",
             out_of_mem_count, no_info_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
